FILE: hw/rtl/wpc_pkg.sv
`default_nettype none
package wpc_pkg;

  // Field widths
  localparam int MOIST_W = 10;
  localparam int LIMIT_W = 8;
  localparam int TICK_W  = 9;
  localparam int CFG_W   = 10;
  localparam int IDX_W   = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LOW_THR   = 3'd0;
  localparam logic [IDX_W-1:0] REG_HIGH_THR  = 3'd1;
  localparam logic [IDX_W-1:0] REG_AUTO_LIM  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MANUAL_RUN = 3'd3;

  // Reset values of the registers
  localparam logic [MOIST_W-1:0] LOW_THR_RST    = 10'd500;
  localparam logic [MOIST_W-1:0] HIGH_THR_RST   = 10'd800;
  localparam logic [LIMIT_W-1:0] AUTO_LIM_RST   = 8'd10;
  localparam logic [LIMIT_W-1:0] MANUAL_RUN_RST = 8'd5;

  // Timer stops here
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  typedef enum logic [1:0] {
    LED_GREEN  = 2'd0,
    LED_YELLOW = 2'd1,
    LED_RED    = 2'd2
  } led_t;

  typedef struct packed {
    logic [MOIST_W-1:0] low_thr;
    logic [MOIST_W-1:0] high_thr;
    logic [LIMIT_W-1:0] auto_lim;
    logic [LIMIT_W-1:0] manual_run;
  } cfg_t;

  typedef struct packed {
    logic              manual;
    logic              pump;
    logic [TICK_W-1:0] ticks;
    led_t              led;
  } ctl_state_t;

  typedef struct packed {
    logic [MOIST_W-1:0] moisture;
    logic               mode_button;
    logic               water_button;
  } tick_in_t;

endpackage
`default_nettype wire

FILE: hw/rtl/wpc_cfg.sv
`default_nettype none
module wpc_cfg
  import wpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write, drop indexes past the list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_LOW_THR:    cfg_nxt.low_thr    = cfg_wdata;
        REG_HIGH_THR:   cfg_nxt.high_thr   = cfg_wdata;
        REG_AUTO_LIM:   cfg_nxt.auto_lim   = cfg_wdata[LIMIT_W-1:0];
        REG_MANUAL_RUN: cfg_nxt.manual_run = cfg_wdata[LIMIT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr    <= LOW_THR_RST;
      cfg_r.high_thr   <= HIGH_THR_RST;
      cfg_r.auto_lim   <= AUTO_LIM_RST;
      cfg_r.manual_run <= MANUAL_RUN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hw/rtl/wpc_step.sv
`default_nettype none
module wpc_step
  import wpc_pkg::*;
(
  input  wire ctl_state_t cur,
  input  wire cfg_t       cfg,
  input  wire tick_in_t   tick,
  output ctl_state_t      nxt
);

  always_comb begin
    nxt = cur;

    // Mode toggle first; entering manual stops the pump
    if (tick.mode_button) begin
      if (!cur.manual) begin
        nxt.manual = 1'b1;
        nxt.pump   = 1'b0;
      end else begin
        nxt.manual = 1'b0;
      end
    end

    // Manual start request
    if (nxt.manual && tick.water_button && !nxt.pump) begin
      nxt.pump  = 1'b1;
      nxt.ticks = '0;
    end

    if (!nxt.manual) begin
      // Auto: hysteresis with run timeout
      if ((tick.moisture < cfg.low_thr) && !nxt.pump) begin
        nxt.pump  = 1'b1;
        nxt.ticks = '0;
        nxt.led   = LED_YELLOW;
      end
      if (nxt.pump) begin
        if (nxt.ticks != TICK_MAX) nxt.ticks = nxt.ticks + 1'b1;
        if ((tick.moisture > cfg.high_thr) ||
            (nxt.ticks > {1'b0, cfg.auto_lim})) begin
          nxt.pump = 1'b0;
          nxt.led  = LED_GREEN;
        end
      end else begin
        nxt.led = LED_GREEN;
      end
    end else begin
      // Manual: timed run
      if (nxt.pump) begin
        if (nxt.ticks != TICK_MAX) nxt.ticks = nxt.ticks + 1'b1;
        nxt.led = LED_YELLOW;
        if (nxt.ticks >= {1'b0, cfg.manual_run}) nxt.pump = 1'b0;
      end else begin
        nxt.led = LED_RED;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/watering_pump_controller_core.sv
// Watering pump controller core.
// Input stream: one beat per control tick; in_tdata carries the moisture
// sample (tenths of a percent) and the mode and water button flags.
// Output stream: one beat per input beat with the pump drive, LED color,
// mode and the run tick count after that tick.
// Configuration: write enable, register index and data; the user must
// write registers only while no tick is in flight; the block does not enforce it.
// Path: an input beat is held in the input register, then passes the step
// logic into the state and result registers.
// Throughput: one tick per cycle while out_tready is high; the controller
// state update is a single pass of compares and a saturating increment.
// Reset: mode auto, pump off, tick count zero, LED green, registers at
// their default values; both stream stages empty.
// Stall: while out_tready is low the result holds and the input register
// keeps one more beat; then in_tready drops.
`default_nettype none
module watering_pump_controller_core
  import wpc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // moisture[9:0], mode_button[10], water_button[11], zero[15:12]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // pump_on[0], led_colour[2:1], manual_mode[3], run_ticks[12:4], zero[15:13]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_we,
  input  wire logic [IDX_W-1:0]       cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  cfg_t       cfg;
  ctl_state_t state_r;
  ctl_state_t state_nxt;
  tick_in_t   tick_r;
  logic       tick_vld_r;
  logic       out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic       advance;
  logic       in_beat;

  wpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wpc_step u_step (
    .cur  (state_r),
    .cfg  (cfg),
    .tick (tick_r),
    .nxt  (state_nxt)
  );

  // Move the held tick into the result stage when it is free
  assign advance   = tick_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !tick_vld_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  // Stage valids and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r    <= 1'b0;
      out_vld_r     <= 1'b0;
      state_r.manual <= 1'b0;
      state_r.pump   <= 1'b0;
      state_r.ticks  <= '0;
      state_r.led    <= LED_GREEN;
    end else begin
      if (in_beat) begin
        tick_vld_r <= 1'b1;
      end else if (advance) begin
        tick_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      tick_r.moisture     <= in_tdata[MOIST_W-1:0];
      tick_r.mode_button  <= in_tdata[MOIST_W];
      tick_r.water_button <= in_tdata[MOIST_W+1];
    end
    if (advance) begin
      out_data_r <= {3'b000, state_nxt.ticks, state_nxt.manual,
                     state_nxt.led, state_nxt.pump};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_vld_r;

endmodule
`default_nettype wire
